// File: rtl/core/rpt_pkg.sv
// Shared types and constants for the regular-expression pattern tokenizer.
package rpt_pkg;

  // One raw pattern byte as it arrives.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_pattern;
  } rpt_in_t;

  // One result token as it leaves.
  typedef struct packed {
    logic [4:0]  token_kind;
    logic [20:0] token_value;
    logic [1:0]  error_code;
    logic        last_of_run;
  } rpt_out_t;

  // Work record passed from the front end to the back end; it stands for
  // an optional token, an optional END token, or an error.
  typedef struct packed {
    logic        has_tok;
    logic [4:0]  kind;
    logic [20:0] value;
    logic [1:0]  err;
    logic        has_end;
  } rpt_rec_t;

  // Token kinds.
  localparam logic [4:0] KIND_LITERAL  = 5'd0;
  localparam logic [4:0] KIND_STAR     = 5'd1;
  localparam logic [4:0] KIND_PLUS     = 5'd2;
  localparam logic [4:0] KIND_QUEST    = 5'd3;
  localparam logic [4:0] KIND_LPAREN   = 5'd4;
  localparam logic [4:0] KIND_RPAREN   = 5'd5;
  localparam logic [4:0] KIND_LBRACKET = 5'd6;
  localparam logic [4:0] KIND_RBRACKET = 5'd7;
  localparam logic [4:0] KIND_LBRACE   = 5'd8;
  localparam logic [4:0] KIND_RBRACE   = 5'd9;
  localparam logic [4:0] KIND_PIPE     = 5'd10;
  localparam logic [4:0] KIND_DOT      = 5'd11;
  localparam logic [4:0] KIND_ESC_W_LO = 5'd12;
  localparam logic [4:0] KIND_ESC_W_UP = 5'd13;
  localparam logic [4:0] KIND_ESC_D_LO = 5'd14;
  localparam logic [4:0] KIND_ESC_D_UP = 5'd15;
  localparam logic [4:0] KIND_ESC_A_LO = 5'd16;
  localparam logic [4:0] KIND_ESC_S_LO = 5'd17;
  localparam logic [4:0] KIND_ESC_S_UP = 5'd18;
  localparam logic [4:0] KIND_ESC_L_LO = 5'd19;
  localparam logic [4:0] KIND_ESC_U_LO = 5'd20;
  localparam logic [4:0] KIND_END      = 5'd21;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BACKSLASH = 2'd1;
  localparam logic [1:0] ERR_UTF8      = 2'd2;

endpackage

// File: rtl/core/rpt_front.sv
// Front end: accepts pattern bytes, tracks escape and UTF-8 state, builds work records.
module rpt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  rpt_pkg::rpt_in_t item,
  output logic            rec_push,
  output rpt_pkg::rpt_rec_t rec
);
  import rpt_pkg::*;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  logic        esc;
  logic [1:0]  left;
  logic [20:0] acc;
  logic        esc_next;
  logic [1:0]  left_next;
  logic [20:0] acc_next;

  logic [7:0]  b;
  logic        fin;
  logic [20:0] nv;
  logic [4:0]  kind;
  logic [20:0] value;
  logic        have;
  logic        decode;
  logic        fail;
  logic [1:0]  fail_code;

  // Operator kind of a plain byte, literal when it is not a metacharacter.
  function automatic logic [4:0] operator_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h2A:   k = KIND_STAR;
      8'h2B:   k = KIND_PLUS;
      8'h3F:   k = KIND_QUEST;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h5B:   k = KIND_LBRACKET;
      8'h5D:   k = KIND_RBRACKET;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h7C:   k = KIND_PIPE;
      8'h2E:   k = KIND_DOT;
      default: k = KIND_LITERAL;
    endcase
    return k;
  endfunction

  // Class-escape kind of an escaped byte, literal when it is not a class letter.
  function automatic logic [4:0] escape_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h77:   k = KIND_ESC_W_LO;
      8'h57:   k = KIND_ESC_W_UP;
      8'h64:   k = KIND_ESC_D_LO;
      8'h44:   k = KIND_ESC_D_UP;
      8'h61:   k = KIND_ESC_A_LO;
      8'h73:   k = KIND_ESC_S_LO;
      8'h53:   k = KIND_ESC_S_UP;
      8'h6C:   k = KIND_ESC_L_LO;
      8'h75:   k = KIND_ESC_U_LO;
      default: k = KIND_LITERAL;
    endcase
    return k;
  endfunction

  assign b   = item.data_byte;
  assign fin = item.end_of_pattern;
  assign nv  = {acc[14:0], b[5:0]};

  // Classify the byte and work out the next lexer state.
  always_comb begin
    esc_next  = esc;
    left_next = left;
    acc_next  = acc;
    kind      = KIND_LITERAL;
    value     = '0;
    have      = 1'b0;
    decode    = 1'b0;
    fail      = 1'b0;
    fail_code = ERR_NONE;

    if (left != 2'd0) begin
      // Continuation byte of a multi-byte character.
      if (b[7:6] != 2'b10) begin
        fail      = 1'b1;
        fail_code = ERR_UTF8;
      end else if (left == 2'd3 && (nv < 21'h10 || nv > 21'h10F)) begin
        fail      = 1'b1;
        fail_code = ERR_UTF8;
      end else if (left == 2'd2 && acc < 21'h10 &&
                   (nv < 21'h20 || (nv >= 21'h360 && nv <= 21'h37F))) begin
        fail      = 1'b1;
        fail_code = ERR_UTF8;
      end else begin
        acc_next  = nv;
        left_next = left - 2'd1;
        if (left == 2'd1) begin
          value    = nv;
          acc_next = '0;
          have     = 1'b1;
        end
      end
    end else if (esc) begin
      esc_next = 1'b0;
      kind     = escape_kind(b);
      if (kind != KIND_LITERAL) begin
        value = {13'd0, b};
        have  = 1'b1;
      end else begin
        decode = 1'b1;
      end
    end else if (b == CH_BACKSLASH) begin
      if (fin) begin
        fail      = 1'b1;
        fail_code = ERR_BACKSLASH;
      end else begin
        esc_next = 1'b1;
      end
    end else begin
      kind = operator_kind(b);
      if (kind != KIND_LITERAL) begin
        value = {13'd0, b};
        have  = 1'b1;
      end else begin
        decode = 1'b1;
      end
    end

    // First byte of a literal character.
    if (decode) begin
      if (b < 8'h80) begin
        value = {13'd0, b};
        have  = 1'b1;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        acc_next  = {16'd0, b[4:0]};
        left_next = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        acc_next  = {17'd0, b[3:0]};
        left_next = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        acc_next  = {18'd0, b[2:0]};
        left_next = 2'd3;
      end else begin
        fail      = 1'b1;
        fail_code = ERR_UTF8;
      end
    end

    // A pattern that ends inside a character is truncated.
    if (!fail && fin && left_next != 2'd0) begin
      fail      = 1'b1;
      fail_code = ERR_UTF8;
    end
  end

  // Work record for the back end.
  always_comb begin
    if (fail) begin
      rec.has_tok = 1'b1;
      rec.kind    = KIND_LITERAL;
      rec.value   = '0;
      rec.err     = fail_code;
      rec.has_end = 1'b0;
    end else begin
      rec.has_tok = have;
      rec.kind    = kind;
      rec.value   = value;
      rec.err     = ERR_NONE;
      rec.has_end = fin;
    end
  end

  assign rec_push = accept && (fail || have || fin);

  // Lexer state; an error or the end of a pattern starts afresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      esc  <= 1'b0;
      left <= 2'd0;
      acc  <= '0;
    end else if (accept) begin
      if (fail || fin) begin
        esc  <= 1'b0;
        left <= 2'd0;
        acc  <= '0;
      end else begin
        esc  <= esc_next;
        left <= left_next;
        acc  <= acc_next;
      end
    end
  end

endmodule

// File: rtl/core/rpt_fifo.sv
// Short queue of work records between the front end and the back end.
module rpt_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  rpt_pkg::rpt_rec_t wr_data,
  input  logic              rd_en,
  output logic              full,
  output logic              nonempty,
  output rpt_pkg::rpt_rec_t rd_data
);
  import rpt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rpt_rec_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;

  // Record storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/rpt_back.sv
// Back end: expands each work record into one or two result tokens.
module rpt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              rec_avail,
  input  rpt_pkg::rpt_rec_t rec_in,
  output logic              rec_take,
  output logic              empty,
  input  logic              pop,
  output rpt_pkg::rpt_out_t token
);
  import rpt_pkg::*;

  rpt_rec_t cur;
  logic     cur_valid;
  logic     phase;
  logic     two;
  logic     pop_acc;
  logic     done;

  assign two     = cur.has_tok && cur.has_end;
  assign pop_acc = pop && cur_valid;
  assign done    = pop_acc && !(two && !phase);
  assign rec_take = rec_avail && (!cur_valid || done);
  assign empty   = !cur_valid;

  // Present either the record's own token or the END token.
  always_comb begin
    if (!phase && cur.has_tok) begin
      token.token_kind  = cur.kind;
      token.token_value = cur.value;
      token.error_code  = cur.err;
      token.last_of_run = !cur.has_end;
    end else begin
      token.token_kind  = KIND_END;
      token.token_value = '0;
      token.error_code  = ERR_NONE;
      token.last_of_run = 1'b1;
    end
  end

  // Current record and the position within it.
  always_ff @(posedge clk) begin
    if (rec_take) begin
      cur <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (rec_take) begin
      cur_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (pop_acc) begin
      phase <= 1'b1;
    end
  end

endmodule

// File: rtl/core/regex_pattern_tokenizer.sv
// Top level of the regular-expression pattern tokenizer.
//
//   Channel   Direction  Request when            Payload
//   pattern   in         push && !full           pattern_item (data_byte, end_of_pattern)
//   tokens    out        pop && !empty           token (token_kind, token_value,
//                                                       error_code, last_of_run)
//
// One pattern byte is accepted every cycle while the record queue has room.
// A byte's work record enters the queue at the accepting edge; its first token appears
// once the back end loads it into its current record. The back end delivers one token
// per cycle while pop is high, so a byte that yields a token and END gives two tokens.
// full rises when the QUEUE_DEPTH-entry record queue is full; output stalls never
// block input until then. Synchronous reset clears the lexer state, queue and output.
module regex_pattern_tokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rpt_pkg::rpt_in_t  pattern_item,
  output logic              empty,
  input  logic              pop,
  output rpt_pkg::rpt_out_t token
);
  import rpt_pkg::*;

  logic     accept;
  logic     rec_push;
  rpt_rec_t rec_wr;
  rpt_rec_t rec_rd;
  logic     rec_avail;
  logic     rec_take;

  assign accept = push && !full;

  // Byte classification and lexer state.
  rpt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (pattern_item),
    .rec_push (rec_push),
    .rec      (rec_wr)
  );

  // Decoupling queue.
  rpt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_push),
    .wr_data  (rec_wr),
    .rd_en    (rec_take),
    .full     (full),
    .nonempty (rec_avail),
    .rd_data  (rec_rd)
  );

  // Token delivery.
  rpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_avail (rec_avail),
    .rec_in    (rec_rd),
    .rec_take  (rec_take),
    .empty     (empty),
    .pop       (pop),
    .token     (token)
  );

endmodule

// File: tb/regex_pattern_tokenizer_test.sv
// Self-checking testbench for the regular-expression pattern tokenizer.
module regex_pattern_tokenizer_test;
  import rpt_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int ITEM_TARGET  = 1800;
  localparam int STALL_AT     = 300;
  localparam int STALL_CYCLES = 200;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 1000;
  localparam int DRAIN_AT     = 1200;
  localparam int IDLE_PCT     = 24;
  localparam int REPORT_MAX   = 10;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  rpt_in_t  pattern_item = '0;
  logic     full;
  logic     empty;
  rpt_out_t token;

  regex_pattern_tokenizer DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pattern_item (pattern_item),
    .empty        (empty),
    .pop          (pop),
    .token        (token)
  );

  // Bytes waiting to be offered, and tokens still owed by the block.
  rpt_in_t    pattern_backlog[$];
  rpt_out_t   token_expect[$];
  logic [7:0] pat_bytes[$];

  // Lexer state as the checker tracks it.
  logic        esc_pend  = 1'b0;
  logic [1:0]  utf8_left = 2'd0;
  logic [20:0] cp_accum  = 21'd0;

  int accepted_count = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int stall_left     = 0;
  bit stall_done     = 1'b0;
  bit drain_done     = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] operator_code(input logic [7:0] b);
    case (b)
      "*":     return KIND_STAR;
      "+":     return KIND_PLUS;
      "?":     return KIND_QUEST;
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "[":     return KIND_LBRACKET;
      "]":     return KIND_RBRACKET;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      "|":     return KIND_PIPE;
      ".":     return KIND_DOT;
      default: return KIND_LITERAL;
    endcase
  endfunction

  function automatic logic [4:0] escape_code(input logic [7:0] b);
    case (b)
      "w":     return KIND_ESC_W_LO;
      "W":     return KIND_ESC_W_UP;
      "d":     return KIND_ESC_D_LO;
      "D":     return KIND_ESC_D_UP;
      "a":     return KIND_ESC_A_LO;
      "s":     return KIND_ESC_S_LO;
      "S":     return KIND_ESC_S_UP;
      "l":     return KIND_ESC_L_LO;
      "u":     return KIND_ESC_U_LO;
      default: return KIND_LITERAL;
    endcase
  endfunction

  // An error token ends the pattern and returns the lexer to its idle state.
  task automatic flag_error(input logic [1:0] err);
    rpt_out_t tok;
    esc_pend  = 1'b0;
    utf8_left = 2'd0;
    cp_accum  = 21'd0;
    tok.token_kind  = KIND_LITERAL;
    tok.token_value = 21'd0;
    tok.error_code  = err;
    tok.last_of_run = 1'b1;
    token_expect.push_back(tok);
  endtask

  // Works out the tokens that one accepted byte causes.
  task automatic tokenize_byte(input rpt_in_t item);
    logic [7:0]  b;
    logic        fin;
    logic [4:0]  kind;
    logic [20:0] value;
    logic        have;
    logic [20:0] nv;
    rpt_out_t    tok;
    b     = item.data_byte;
    fin   = item.end_of_pattern;
    kind  = KIND_LITERAL;
    value = 21'd0;
    have  = 1'b0;

    if (utf8_left != 2'd0) begin
      // Continuation byte of a multi-byte character.
      if (b[7:6] != 2'b10) begin
        flag_error(ERR_UTF8);
        return;
      end
      nv = {cp_accum[14:0], b[5:0]};
      if (utf8_left == 2'd3) begin
        if (nv < 21'h10 || nv > 21'h10F) begin
          flag_error(ERR_UTF8);
          return;
        end
      end else if (utf8_left == 2'd2 && cp_accum < 21'h10) begin
        if (nv < 21'h20 || (nv >= 21'h360 && nv <= 21'h37F)) begin
          flag_error(ERR_UTF8);
          return;
        end
      end
      cp_accum  = nv;
      utf8_left = utf8_left - 2'd1;
      if (utf8_left == 2'd0) begin
        value    = cp_accum;
        cp_accum = 21'd0;
        have     = 1'b1;
      end
    end else if (esc_pend) begin
      esc_pend = 1'b0;
      kind     = escape_code(b);
      if (kind != KIND_LITERAL) begin
        value = {13'd0, b};
        have  = 1'b1;
      end
    end else if (b == CHAR_BACKSLASH) begin
      if (fin) begin
        flag_error(ERR_BACKSLASH);
        return;
      end
      esc_pend = 1'b1;
      return;
    end else begin
      kind = operator_code(b);
      if (kind != KIND_LITERAL) begin
        value = {13'd0, b};
        have  = 1'b1;
      end
    end

    // First byte of a literal character.
    if (!have && utf8_left == 2'd0 && kind == KIND_LITERAL && cp_accum == 21'd0) begin
      if (b < 8'h80) begin
        value = {13'd0, b};
        have  = 1'b1;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        cp_accum  = {16'd0, b[4:0]};
        utf8_left = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        cp_accum  = {17'd0, b[3:0]};
        utf8_left = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        cp_accum  = {18'd0, b[2:0]};
        utf8_left = 2'd3;
      end else begin
        flag_error(ERR_UTF8);
        return;
      end
    end

    if (fin && utf8_left != 2'd0) begin
      flag_error(ERR_UTF8);
      return;
    end

    if (have) begin
      tok.token_kind  = kind;
      tok.token_value = value;
      tok.error_code  = ERR_NONE;
      tok.last_of_run = !fin;
      token_expect.push_back(tok);
    end
    if (fin) begin
      tok.token_kind  = KIND_END;
      tok.token_value = 21'd0;
      tok.error_code  = ERR_NONE;
      tok.last_of_run = 1'b1;
      token_expect.push_back(tok);
      esc_pend  = 1'b0;
      utf8_left = 2'd0;
      cp_accum  = 21'd0;
    end
  endtask

  // Compares one delivered token with the oldest one owed.
  task automatic check_token(input rpt_out_t got);
    rpt_out_t want;
    if (token_expect.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("unexpected token: kind %0d value %h err %0d last %b",
                 got.token_kind, got.token_value, got.error_code, got.last_of_run);
    end else begin
      want = token_expect.pop_front();
      if (got.token_kind !== want.token_kind || got.token_value !== want.token_value ||
          got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("token differs: expected kind %0d value %h err %0d last %b",
                   want.token_kind, want.token_value, want.error_code, want.last_of_run);
          $display("               got kind %0d value %h err %0d last %b",
                   got.token_kind, got.token_value, got.error_code, got.last_of_run);
        end
      end
    end
  endtask

  task automatic add_item(input logic [7:0] b, input logic eop);
    rpt_in_t item;
    item.data_byte      = b;
    item.end_of_pattern = eop;
    pattern_backlog.push_back(item);
  endtask

  // UTF-8 encoding of a codepoint, without any validity check.
  task automatic put_codepoint(input logic [20:0] cp);
    if (cp < 21'h80) begin
      pat_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      pat_bytes.push_back({3'b110, cp[10:6]});
      pat_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      pat_bytes.push_back({4'b1110, cp[15:12]});
      pat_bytes.push_back({2'b10, cp[11:6]});
      pat_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      pat_bytes.push_back({5'b11110, cp[20:18]});
      pat_bytes.push_back({2'b10, cp[17:12]});
      pat_bytes.push_back({2'b10, cp[11:6]});
      pat_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  function automatic logic [20:0] valid_codepoint();
    logic [20:0] cp;
    case ($urandom_range(3))
      0:       cp = 21'($urandom_range(8'h7F, 0));
      1:       cp = 21'($urandom_range(16'h7FF, 16'h80));
      2: begin
        cp = 21'($urandom_range(16'hFFFF, 16'h800));
        if (cp >= 21'hD800 && cp <= 21'hDFFF)
          cp = cp ^ 21'h8000;
      end
      default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
    endcase
    return cp;
  endfunction

  // Appends a malformed character; returns 1 when the pattern must stop here.
  task automatic put_broken(output bit stop);
    logic [7:0] b;
    stop = 1'b0;
    case ($urandom_range(5))
      0: begin
        if ($urandom_range(1) == 0)
          pat_bytes.push_back(8'($urandom_range(8'hC1, 8'h80)));
        else
          pat_bytes.push_back(8'($urandom_range(8'hFF, 8'hF5)));
      end
      1: begin
        pat_bytes.push_back(8'($urandom_range(8'hF4, 8'hC2)));
        b = 8'($urandom_range(255));
        if (b[7:6] == 2'b10)
          b[6] = 1'b1;
        pat_bytes.push_back(b);
      end
      2: begin
        // Overlong three- or four-byte form.
        if ($urandom_range(1) == 0) begin
          pat_bytes.push_back(8'hE0);
          pat_bytes.push_back(8'($urandom_range(8'h9F, 8'h80)));
        end else begin
          pat_bytes.push_back(8'hF0);
          pat_bytes.push_back(8'($urandom_range(8'h8F, 8'h80)));
        end
        pat_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end
      3: begin
        // Surrogate half.
        pat_bytes.push_back(8'hED);
        pat_bytes.push_back(8'($urandom_range(8'hBF, 8'hA0)));
        pat_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end
      4: begin
        // Beyond the last codepoint.
        pat_bytes.push_back(8'hF4);
        pat_bytes.push_back(8'($urandom_range(8'hBF, 8'h90)));
        pat_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
        pat_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end
      default: begin
        // Truncated sequence: the pattern ends before the character does.
        put_codepoint(21'($urandom_range(21'h10FFFF, 21'h80)));
        repeat ($urandom_range(1, 1)) void'(pat_bytes.pop_back());
        if (pat_bytes.size() > 1 && $urandom_range(1) == 0 &&
            pat_bytes[pat_bytes.size() - 1][7:6] == 2'b10)
          void'(pat_bytes.pop_back());
        stop = 1'b1;
      end
    endcase
  endtask

  // One random token's worth of bytes, mostly well formed.
  task automatic put_token(output bit stop);
    int         sel;
    logic [7:0] ops[11];
    logic [7:0] escs[9];
    ops  = '{"*", "+", "?", "(", ")", "[", "]", "{", "}", "|", "."};
    escs = '{"w", "W", "d", "D", "a", "s", "S", "l", "u"};
    stop = 1'b0;
    sel  = $urandom_range(99);
    if (sel < 20) begin
      pat_bytes.push_back(ops[$urandom_range(10)]);
    end else if (sel < 32) begin
      pat_bytes.push_back(CHAR_BACKSLASH);
      pat_bytes.push_back(escs[$urandom_range(8)]);
    end else if (sel < 40) begin
      // Escaped metacharacter or any other escaped character.
      pat_bytes.push_back(CHAR_BACKSLASH);
      if ($urandom_range(1) == 0)
        pat_bytes.push_back(ops[$urandom_range(10)]);
      else
        put_codepoint(valid_codepoint());
    end else if (sel < 90) begin
      put_codepoint(valid_codepoint());
    end else begin
      put_broken(stop);
    end
  endtask

  // Builds one pattern, or a burst of noise, onto the backlog.
  task automatic queue_pattern();
    int n;
    bit stop;
    pat_bytes.delete();
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++)
        add_item(8'($urandom_range(255)), $urandom_range(7) == 0);
    end else begin
      n    = $urandom_range(8, 1);
      stop = 1'b0;
      for (int i = 0; i < n && !stop; i++)
        put_token(stop);
      if (!stop && $urandom_range(99) < 4)
        pat_bytes.push_back(CHAR_BACKSLASH);
      for (int i = 0; i < pat_bytes.size(); i++)
        add_item(pat_bytes[i], i == pat_bytes.size() - 1);
    end
  endtask

  // Sender: offers the backlog, holds a request while full is high.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        tokenize_byte(pattern_item);
        accepted_count++;
      end
      if (!(push && full)) begin
        if (!drain_done && accepted_count >= DRAIN_AT && token_expect.size() != 0) begin
          push <= 1'b0;
        end else begin
          if (accepted_count >= DRAIN_AT)
            drain_done = 1'b1;
          if (pattern_backlog.size() != 0 &&
              ((accepted_count >= CALM_FROM && accepted_count < CALM_TO) ||
               $urandom_range(99) >= IDLE_PCT)) begin
            pattern_item <= pattern_backlog.pop_front();
            push         <= 1'b1;
          end else begin
            push <= 1'b0;
          end
        end
      end
    end
  end

  // Receiver: checks each popped token, with one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        check_token(token);
      if (!stall_done && accepted_count >= STALL_AT) begin
        stall_done <= 1'b1;
        stall_left <= STALL_CYCLES;
        pop        <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        pop        <= 1'b0;
      end else begin
        pop <= (accepted_count >= CALM_FROM && accepted_count < CALM_TO) ||
               ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("regex_pattern_tokenizer: mismatch");
      $finish;
    end
  end

  initial begin
    // Directed patterns: every operator, class escapes and the error cases.
    add_item("*", 1'b0);
    add_item("+", 1'b0);
    add_item("?", 1'b0);
    add_item("(", 1'b0);
    add_item(")", 1'b0);
    add_item("[", 1'b0);
    add_item("]", 1'b0);
    add_item("{", 1'b0);
    add_item("}", 1'b0);
    add_item("|", 1'b0);
    add_item(".", 1'b1);
    add_item(CHAR_BACKSLASH, 1'b0);
    add_item("w", 1'b0);
    add_item(CHAR_BACKSLASH, 1'b0);
    add_item("u", 1'b1);
    // Backslash on the final byte.
    add_item(CHAR_BACKSLASH, 1'b1);
    // Invalid lead byte.
    add_item(8'hFF, 1'b0);
    // Lead byte carrying the end flag.
    add_item(8'hC3, 1'b1);
    // Surrogate half.
    add_item(8'hED, 1'b0);
    add_item(8'hA0, 1'b0);
    // Highest codepoint, then the lowest byte.
    add_item(8'hF4, 1'b0);
    add_item(8'h8F, 1'b0);
    add_item(8'hBF, 1'b0);
    add_item(8'hBF, 1'b1);
    add_item(8'h00, 1'b1);

    while (pattern_backlog.size() < ITEM_TARGET)
      queue_pattern();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pattern_backlog.size() != 0 || push)
      @(posedge clk);
    while (token_expect.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0)
      $display("regex_pattern_tokenizer: match");
    else
      $display("regex_pattern_tokenizer: mismatch");
    $finish;
  end

endmodule
